FILE: hdl/brt_pkg.sv
// Shared types, codes and reset values of the backoff retry table.
`timescale 1ns / 1ps

package brt_pkg;

    // Request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_CHECK = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_BASE   = 2'd0;
    localparam logic [1:0] REG_CAP    = 2'd1;
    localparam logic [1:0] REG_SHIFT  = 2'd2;
    localparam logic [1:0] REG_PERIOD = 2'd3;

    // Register reset values
    localparam logic [15:0] BASE_RST   = 16'd100;
    localparam logic [19:0] CAP_RST    = 20'd6000;
    localparam logic [3:0]  SHIFT_RST  = 4'd10;
    localparam logic [9:0]  PERIOD_RST = 10'd10;

    // Positive ticks left always fit in 31 bits
    localparam int TICKW = 31;

    typedef struct packed {
        logic [15:0] base_delay;
        logic [19:0] cap_delay;
        logic [3:0]  max_shift;
        logic [9:0]  tick_period;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        ready_res;
        logic [31:0] wait_ms;
        logic [31:0] next_delay_ms;
    } res_t;

endpackage

FILE: hdl/brt_ms_mul.sv
// Registered tick to millisecond multiplier with saturation.
`timescale 1ns / 1ps

module brt_ms_mul
    import brt_pkg::*;
(
    input  logic             clk,
    input  logic [TICKW-1:0] ticks,
    input  logic [9:0]       period,
    output logic [31:0]      ms
);

    logic [TICKW+9:0] prod;
    logic [31:0]      ms_reg;

    // Multiply ticks by the tick period
    assign prod = {10'd0, ticks} * {{TICKW{1'b0}}, period};

    // Saturate to 32 bits and register
    always_ff @(posedge clk)
    begin
        ms_reg <= (|prod[TICKW+9:32]) ? 32'hFFFF_FFFF : prod[31:0];
    end

    assign ms = ms_reg;

endmodule

FILE: hdl/brt_core.sv
// Sequencer, slot memories and compare unit of the backoff retry table.
`timescale 1ns / 1ps

module brt_core
    import brt_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [63:0] job_key,
    input  logic [7:0]  attempts,
    input  logic        res_ok,
    output logic        res_push,
    output res_t        res
);

    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW   = $clog2(SLOTS + 1);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_APPLY,
        S_MS_REM,
        S_MS_NEXT,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [31:0]       time_now_reg;
    logic [SLOTS-1:0]  used_reg;

    // Latched request
    logic [1:0]        req_reg;
    logic [63:0]       key_reg;
    logic [19:0]       delay_reg;
    logic              lookup_reg;

    // Walk pipeline
    logic [CW-1:0]     issue_cnt_reg;
    logic              a_vld_reg;
    logic [IDXW-1:0]   a_idx_reg;
    logic              a_used_reg;
    logic              b_vld_reg;
    logic [IDXW-1:0]   b_idx_reg;
    logic              b_used_reg;
    logic              b_hit_reg;
    logic [TICKW-1:0]  b_t_reg;

    // Walk trackers
    logic              match_reg;
    logic [IDXW-1:0]   match_idx_reg;
    logic [TICKW-1:0]  match_t_reg;
    logic              free_reg;
    logic [IDXW-1:0]   free_idx_reg;
    logic [TICKW-1:0]  best_reg;

    // Result
    logic [1:0]        status_reg;
    logic              ready_reg;
    logic [TICKW-1:0]  rem_reg;
    logic [31:0]       rem_ms_reg;

    // Memories
    logic [63:0]       key_mem [SLOTS];
    logic [31:0]       dl_mem  [SLOTS];
    logic [63:0]       key_rd_reg;
    logic [31:0]       dl_rd_reg;

    logic              accept;
    logic              issue;
    logic [IDXW-1:0]   rd_idx;
    logic [31:0]       dl_diff;
    logic [TICKW-1:0]  a_t;
    logic              a_hit;
    logic [7:0]        att_m1;
    logic [3:0]        shift_amt;
    logic [31:0]       shifted;
    logic [19:0]       delay_new;

    logic [1:0]        ap_status;
    logic              ap_ready;
    logic [TICKW-1:0]  ap_rem;
    logic [TICKW-1:0]  ap_x;
    logic              ap_set;
    logic              ap_clr;
    logic [IDXW-1:0]   ap_idx;
    logic [TICKW-1:0]  ap_best;
    logic              mem_we;
    logic [31:0]       dl_wr;

    logic [TICKW-1:0]  mul_ticks;
    logic [31:0]       mul_ms;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign issue    = (state_reg == S_WALK) && (issue_cnt_reg != CW'(SLOTS));
    assign rd_idx   = issue_cnt_reg[IDXW-1:0];

    // Backoff delay of the incoming request
    always_comb
    begin
        att_m1    = attempts - 8'd1;
        shift_amt = (att_m1 > {4'd0, cfg.max_shift}) ? cfg.max_shift : att_m1[3:0];
        shifted   = {16'd0, cfg.base_delay} << shift_amt;
        if (attempts == 8'd0)
        begin
            delay_new = 20'd0;
        end
        else if (shifted > {12'd0, cfg.cap_delay})
        begin
            delay_new = cfg.cap_delay;
        end
        else
        begin
            delay_new = shifted[19:0];
        end
    end

    // Ticks left and key match of the slot read last cycle
    always_comb
    begin
        dl_diff = dl_rd_reg - time_now_reg;
        a_t     = (dl_diff == 32'd0 || dl_diff[31]) ? '0 : dl_diff[TICKW-1:0];
        a_hit   = a_used_reg && lookup_reg && (key_rd_reg == key_reg);
    end

    // Decide the table update and result fields after the walk
    always_comb
    begin
        ap_status = ST_OK;
        ap_ready  = 1'b0;
        ap_rem    = '0;
        ap_x      = '0;
        ap_set    = 1'b0;
        ap_clr    = 1'b0;
        ap_idx    = match_idx_reg;
        if (!lookup_reg)
        begin
            if (req_reg != REQ_TICK)
            begin
                ap_status = ST_EMPTY;
                ap_ready  = (req_reg == REQ_CHECK);
            end
        end
        else
        begin
            case (req_reg)
                REQ_SET:
                begin
                    if (match_reg)
                    begin
                        ap_set = 1'b1;
                    end
                    else if (free_reg)
                    begin
                        ap_set = 1'b1;
                        ap_idx = free_idx_reg;
                    end
                    else
                    begin
                        ap_status = ST_FULL;
                    end
                    ap_x = ap_set ? TICKW'(delay_reg) : '0;
                end
                REQ_CLEAR:
                begin
                    if (match_reg)
                    begin
                        ap_clr = 1'b1;
                    end
                    else
                    begin
                        ap_status = ST_NOTFOUND;
                    end
                end
                REQ_CHECK:
                begin
                    if (match_reg)
                    begin
                        ap_ready = (match_t_reg == '0);
                        ap_rem   = match_t_reg;
                        ap_x     = match_t_reg;
                    end
                    else
                    begin
                        ap_status = ST_NOTFOUND;
                        ap_ready  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        ap_best = (ap_x != '0 && (best_reg == '0 || ap_x < best_reg)) ? ap_x : best_reg;
    end

    assign mem_we = (state_reg == S_APPLY) && ap_set;
    assign dl_wr  = time_now_reg + {12'd0, delay_reg};

    // Slot key and deadline memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[ap_idx] <= key_reg;
            dl_mem[ap_idx]  <= dl_wr;
        end
        key_rd_reg <= key_mem[rd_idx];
        dl_rd_reg  <= dl_mem[rd_idx];
    end

    // Share one multiplier for remaining and next delay
    assign mul_ticks = (state_reg == S_MS_REM) ? rem_reg : best_reg;

    brt_ms_mul u_ms_mul (
        .clk    (clk),
        .ticks  (mul_ticks),
        .period (cfg.tick_period),
        .ms     (mul_ms)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_now_reg  <= 32'd0;
            used_reg      <= '0;
            req_reg       <= REQ_TICK;
            key_reg       <= 64'd0;
            delay_reg     <= 20'd0;
            lookup_reg    <= 1'b0;
            issue_cnt_reg <= '0;
            a_vld_reg     <= 1'b0;
            a_idx_reg     <= '0;
            a_used_reg    <= 1'b0;
            b_vld_reg     <= 1'b0;
            b_idx_reg     <= '0;
            b_used_reg    <= 1'b0;
            b_hit_reg     <= 1'b0;
            b_t_reg       <= '0;
            match_reg     <= 1'b0;
            match_idx_reg <= '0;
            match_t_reg   <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            best_reg      <= '0;
            status_reg    <= ST_OK;
            ready_reg     <= 1'b0;
            rem_reg       <= '0;
            rem_ms_reg    <= 32'd0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg       <= req_type;
                        key_reg       <= job_key;
                        delay_reg     <= delay_new;
                        lookup_reg    <= (req_type != REQ_TICK) && (job_key != 64'd0);
                        issue_cnt_reg <= '0;
                        a_vld_reg     <= 1'b0;
                        b_vld_reg     <= 1'b0;
                        match_reg     <= 1'b0;
                        free_reg      <= 1'b0;
                        best_reg      <= '0;
                        if (req_type == REQ_TICK)
                        begin
                            time_now_reg <= time_now_reg + 32'd1;
                        end
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    // Issue one slot read per cycle
                    if (issue)
                    begin
                        issue_cnt_reg <= issue_cnt_reg + CW'(1);
                    end
                    a_vld_reg  <= issue;
                    a_idx_reg  <= rd_idx;
                    a_used_reg <= used_reg[rd_idx];
                    // Register the compare result
                    b_vld_reg  <= a_vld_reg;
                    b_idx_reg  <= a_idx_reg;
                    b_used_reg <= a_used_reg;
                    b_hit_reg  <= a_hit;
                    b_t_reg    <= a_t;
                    // Track match, first free slot and smallest positive delay
                    if (b_vld_reg)
                    begin
                        if (b_hit_reg)
                        begin
                            match_reg     <= 1'b1;
                            match_idx_reg <= b_idx_reg;
                            match_t_reg   <= b_t_reg;
                        end
                        else if (b_used_reg && b_t_reg != '0
                                 && (best_reg == '0 || b_t_reg < best_reg))
                        begin
                            best_reg <= b_t_reg;
                        end
                        if (!b_used_reg && !free_reg)
                        begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= b_idx_reg;
                        end
                        if (b_idx_reg == LAST_IDX)
                        begin
                            state_reg <= S_APPLY;
                        end
                    end
                end
                S_APPLY:
                begin
                    if (ap_set)
                    begin
                        used_reg[ap_idx] <= 1'b1;
                    end
                    if (ap_clr)
                    begin
                        used_reg[ap_idx] <= 1'b0;
                    end
                    status_reg <= ap_status;
                    ready_reg  <= ap_ready;
                    rem_reg    <= ap_ready ? '0 : ap_rem;
                    best_reg   <= ap_best;
                    state_reg  <= S_MS_REM;
                end
                S_MS_REM:
                begin
                    state_reg <= S_MS_NEXT;
                end
                S_MS_NEXT:
                begin
                    rem_ms_reg <= mul_ms;
                    state_reg  <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_ok)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_push          = (state_reg == S_DONE) && res_ok;
    assign res.status        = status_reg;
    assign res.ready_res     = ready_reg;
    assign res.wait_ms       = rem_ms_reg;
    assign res.next_delay_ms = mul_ms;

endmodule

FILE: hdl/backoff_retry_table.sv
// Top level of the backoff retry table: register port, core and output register.
//
// channel   direction  handshake            payload
// request   in         in_valid / in_ready  req_type, job_key, attempts
// result    out        out_valid/out_ready  status, ready_res, wait_ms, next_delay_ms
// config    in         psel/penable/pready  paddr, pwdata, prdata
//
// A request passes from accept through the walk, the apply step and the millisecond
// steps to its result; no new request is accepted until the core has pushed it. The walk
// reads one slot of the key/deadline memory per cycle, then one multiplier is used
// twice for the millisecond values. Reset clears the used bits at once, so no
// clearing pass runs. One output register holds a result; the core stalls at its
// last step while that register is full and not being taken.
`timescale 1ns / 1ps

module backoff_retry_table
    import brt_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [63:0] job_key,
    input  logic [7:0]  attempts,
    // Result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        ready_res,
    output logic [31:0] wait_ms,
    output logic [31:0] next_delay_ms
);

    cfg_t        cfg_reg;
    res_t        res;
    res_t        out_reg;
    logic        out_valid_reg;
    logic        res_push;
    logic        res_ok;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_delay  <= BASE_RST;
            cfg_reg.cap_delay   <= CAP_RST;
            cfg_reg.max_shift   <= SHIFT_RST;
            cfg_reg.tick_period <= PERIOD_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_BASE:   cfg_reg.base_delay  <= pwdata[15:0];
                REG_CAP:    cfg_reg.cap_delay   <= pwdata[19:0];
                REG_SHIFT:  cfg_reg.max_shift   <= pwdata[3:0];
                REG_PERIOD: cfg_reg.tick_period <= pwdata[9:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        case (cfg_idx)
            REG_BASE:   prdata = {16'd0, cfg_reg.base_delay};
            REG_CAP:    prdata = {12'd0, cfg_reg.cap_delay};
            REG_SHIFT:  prdata = {28'd0, cfg_reg.max_shift};
            REG_PERIOD: prdata = {22'd0, cfg_reg.tick_period};
            default:    prdata = 32'd0;
        endcase
    end

    brt_core #(
        .SLOTS (SLOTS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .job_key  (job_key),
        .attempts (attempts),
        .res_ok   (res_ok),
        .res_push (res_push),
        .res      (res)
    );

    // Hold the result in the core until the output register can take it
    assign res_ok = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (res_push)
        begin
            out_valid_reg <= 1'b1;
            out_reg       <= res;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign ready_res     = out_reg.ready_res;
    assign wait_ms       = out_reg.wait_ms;
    assign next_delay_ms = out_reg.next_delay_ms;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while the core was still busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (!out_valid_reg || out_ready))
        else $error("result pushed over a waiting result");

    a_push_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !in_ready)
        else $error("result pushed while the core was idle");
`endif

endmodule
